[rtl/core/hmbs_pkg.sv]
// shared types and constants for the heightmap bilinear sampler
package hmbs_pkg;

  localparam int unsigned WorldW   = 24;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned DimW     = 10;
  localparam int unsigned HeightW  = 18;
  localparam int unsigned WorldFrac = 8;
  localparam int unsigned ScaleFrac = 12;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_INV_SCALE_X = 2'd0,
    REG_INV_SCALE_Z = 2'd1,
    REG_MAP_WIDTH   = 2'd2,
    REG_MAP_LENGTH  = 2'd3
  } reg_idx_t;

endpackage

[rtl/core/hmbs_bank.sv]
// one bank of the height store, one write port and one registered read port
module hmbs_bank #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/heightmap_bilinear_sampler.sv]
// heightmap bilinear sampler: one item per cycle unless the output stalls; the output is registered
// throughput: one item per cycle; a stall on the output freezes every stage at once
// the store is held in four full copies, one per corner, so the four corners are read together
// the pipe includes the scale multiply, bank read and two interpolation multiply stages
// reset clears valid bits and loads default registers; the store is undefined until written
module heightmap_bilinear_sampler
  import hmbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_LENGTH = 512,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [17:0]               load_index,
  input  logic [7:0]                load_height,
  input  logic signed [WorldW-1:0]  world_x,
  input  logic signed [WorldW-1:0]  world_z,
  input  logic                      reverse_quad,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [HeightW-1:0] height,
  output logic                      outside_map
);

  localparam int unsigned XW      = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned ZW      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned StoreD  = MAX_WIDTH * MAX_LENGTH;
  localparam int unsigned ProdW   = WorldW + ScaleW + 1;
  localparam int unsigned Shift   = WorldFrac + ScaleFrac - FRAC_BITS;
  localparam int unsigned GridW   = ProdW - Shift;
  localparam int unsigned IntW    = GridW - FRAC_BITS;
  localparam int unsigned OneW    = FRAC_BITS + 1;
  localparam int unsigned CornW   = 11;
  localparam int unsigned RowW    = CornW + OneW + 2;
  localparam int unsigned SumW    = RowW + OneW + 2;
  localparam int unsigned RShift  = 2 * FRAC_BITS - 8;
  localparam logic [OneW-1:0] One = OneW'(1) << FRAC_BITS;

  // ---------------------------------------------------------------------------
  // configuration
  logic [ScaleW-1:0] inv_scale_x, inv_scale_z;
  logic [DimW-1:0]   map_width, map_length;
  logic              cfg_we;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale_x <= ScaleW'(4096);
      inv_scale_z <= ScaleW'(4096);
      map_width   <= DimW'(512);
      map_length  <= DimW'(512);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_INV_SCALE_X: inv_scale_x <= pwdata[ScaleW-1:0];
        REG_INV_SCALE_Z: inv_scale_z <= pwdata[ScaleW-1:0];
        REG_MAP_WIDTH:   map_width   <= pwdata[DimW-1:0];
        REG_MAP_LENGTH:  map_length  <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_INV_SCALE_X: prdata = 32'(inv_scale_x);
      REG_INV_SCALE_Z: prdata = 32'(inv_scale_z);
      REG_MAP_WIDTH:   prdata = 32'(map_width);
      REG_MAP_LENGTH:  prdata = 32'(map_length);
      default:         prdata = '0;
    endcase
  end

  // clamped map size, 13 bits holds up to 8191
  logic [12:0] w_eff, l_eff;
  assign w_eff = (13'(map_width)  > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : 13'(map_width);
  assign l_eff = (13'(map_length) > 13'(MAX_LENGTH)) ? 13'(MAX_LENGTH) : 13'(map_length);

  // whole pipe advances together
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------------------
  // stage 1: scale multiply
  logic               s1_v, s1_q, s1_rev;
  logic signed [ProdW-1:0] s1_px, s1_pz;
  logic [17:0]        s1_idx;
  logic [7:0]         s1_hgt;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q   <= (action == ACT_QUERY);
      s1_rev <= reverse_quad;
      s1_px  <= ProdW'(world_x) * $signed({1'b0, inv_scale_x});
      s1_pz  <= ProdW'(world_z) * $signed({1'b0, inv_scale_z});
      s1_idx <= load_index;
      s1_hgt <= load_height;
    end
  end

  // stage 2: grid split, range check
  logic [GridW-1:0] g1x, g1z;
  assign g1x = s1_px[ProdW-1:Shift];
  assign g1z = s1_pz[ProdW-1:Shift];

  logic               s2_v, s2_q, s2_rev, s2_out;
  logic [IntW-1:0]    s2_xi, s2_zi;
  logic [FRAC_BITS-1:0] s2_fx, s2_fz;
  logic [17:0]        s2_idx;
  logic [7:0]         s2_hgt;
  logic [12:0]        s2_w, s2_l;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_q   <= s1_q;
      s2_rev <= s1_rev;
      s2_out <= s1_px[ProdW-1] || s1_pz[ProdW-1]
             || (g1x[GridW-1:FRAC_BITS] >= IntW'(w_eff))
             || (g1z[GridW-1:FRAC_BITS] >= IntW'(l_eff));
      s2_xi  <= g1x[GridW-1:FRAC_BITS];
      s2_zi  <= g1z[GridW-1:FRAC_BITS];
      s2_fx  <= g1x[FRAC_BITS-1:0];
      s2_fz  <= g1z[FRAC_BITS-1:0];
      s2_idx <= s1_idx;
      s2_hgt <= s1_hgt;
      s2_w   <= w_eff;
      s2_l   <= l_eff;
    end
  end

  // stage 3: corner coordinates, right and top neighbours clamped at the map edge
  logic [XW-1:0] s3_x0, s3_x1;
  logic [ZW-1:0] s3_z0, s3_z1;
  logic          s3_v, s3_q, s3_rev, s3_out;
  logic [FRAC_BITS-1:0] s3_fx, s3_fz;
  logic [12:0]   s3_w;
  logic [17:0]   s3_idx;
  logic [7:0]    s3_hgt;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_q   <= s2_q;
      s3_rev <= s2_rev;
      s3_out <= s2_out;
      s3_fx  <= s2_fx;
      s3_fz  <= s2_fz;
      s3_w   <= s2_w;
      s3_idx <= s2_idx;
      s3_hgt <= s2_hgt;
      s3_x0  <= XW'(s2_xi);
      s3_z0  <= ZW'(s2_zi);
      s3_x1  <= (13'(s2_xi) + 13'd1 < s2_w) ? XW'(s2_xi + IntW'(1)) : XW'(s2_xi);
      s3_z1  <= (13'(s2_zi) + 13'd1 < s2_l) ? ZW'(s2_zi + IntW'(1)) : ZW'(s2_zi);
    end
  end

  // stage 4: linear addresses x + z*w for the four corners
  // the store is replicated into four copies so each corner has its own read port
  localparam int unsigned LinW = 26;
  logic [LinW-1:0] s4_a [4];
  logic            s4_ok [4];
  logic            s4_v, s4_q, s4_rev, s4_out;
  logic [FRAC_BITS-1:0] s4_fx, s4_fz;
  logic [17:0]     s4_idx;
  logic [7:0]      s4_hgt;
  logic [LinW-1:0] zw0, zw1;

  assign zw0 = LinW'(s3_z0) * LinW'(s3_w);
  assign zw1 = LinW'(s3_z1) * LinW'(s3_w);

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_q   <= s3_q;
      s4_rev <= s3_rev;
      s4_out <= s3_out;
      s4_fx  <= s3_fx;
      s4_fz  <= s3_fz;
      s4_idx <= s3_idx;
      s4_hgt <= s3_hgt;
      s4_a[0] <= LinW'(s3_x0) + zw0;
      s4_a[1] <= LinW'(s3_x1) + zw0;
      s4_a[2] <= LinW'(s3_x0) + zw1;
      s4_a[3] <= LinW'(s3_x1) + zw1;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s4_ok[i] = s4_a[i] < LinW'(StoreD);
    end
  end

  // stage 5: memory read; loads write all four copies
  localparam int unsigned StAW = $clog2(StoreD);
  logic       ld_we;
  logic [7:0] rd [4];
  logic       s5_v, s5_rev, s5_out;
  logic       s5_ok [4];
  logic [FRAC_BITS-1:0] s5_fx, s5_fz;

  assign ld_we = adv && s4_v && !s4_q && (32'(s4_idx) < StoreD);

  for (genvar g = 0; g < 4; g++) begin : g_copy
    hmbs_bank #(.Depth(StoreD), .AddrW(StAW)) u_bank (
      .clk   (clk),
      .we    (ld_we),
      .waddr (StAW'(s4_idx)),
      .wdata (s4_hgt),
      .re    (adv),
      .raddr (StAW'(s4_a[g])),
      .rdata (rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (adv) s5_v <= s4_v && s4_q;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_rev <= s4_rev;
      s5_out <= s4_out;
      s5_fx  <= s4_fx;
      s5_fz  <= s4_fz;
      for (int i = 0; i < 4; i++) s5_ok[i] <= s4_ok[i];
    end
  end

  // stage 6: diagonal substitution and row blends
  logic signed [CornW-1:0] bl, br, tl, tr;
  logic signed [OneW:0]    fx_s, fz_s, ofx_s;

  always_comb begin
    bl = s5_ok[0] ? CornW'(rd[0]) : '0;
    br = s5_ok[1] ? CornW'(rd[1]) : '0;
    tl = s5_ok[2] ? CornW'(rd[2]) : '0;
    tr = s5_ok[3] ? CornW'(rd[3]) : '0;
    fx_s  = (OneW+1)'(s5_fx);
    fz_s  = (OneW+1)'(s5_fz);
    ofx_s = (OneW+1)'(One) - fx_s;
    if (s5_rev) begin
      if (fz_s >= fx_s) br = bl + (CornW'(rd[3] & {8{s5_ok[3]}}) - tl);
      else              tl = tr + (bl - br);
    end else begin
      if (fz_s < ofx_s) tr = tl + (br - bl);
      else              bl = tl + (br - tr);
    end
  end

  logic signed [RowW-1:0] s6_top, s6_bot;
  logic                   s6_v, s6_out;
  logic [FRAC_BITS-1:0]   s6_fz;

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (adv) s6_v <= s5_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_out <= s5_out;
      s6_fz  <= s5_fz;
      s6_top <= RowW'(tl) * RowW'(ofx_s) + RowW'(tr) * RowW'(fx_s);
      s6_bot <= RowW'(bl) * RowW'(ofx_s) + RowW'(br) * RowW'(fx_s);
    end
  end

  // stage 7: column blend
  logic signed [SumW-1:0] s7_h;
  logic                   s7_v, s7_out;
  logic signed [OneW:0]   fz7;
  assign fz7 = (OneW+1)'(s6_fz);

  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (adv) s7_v <= s6_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_out <= s6_out;
      s7_h   <= SumW'(s6_bot) * SumW'((OneW+1)'(One) - fz7) + SumW'(s6_top) * SumW'(fz7);
    end
  end

  // stage 8: round half up, saturate, output register
  logic signed [SumW-1:0] rnd;
  always_comb begin
    if (RShift > 0) rnd = (s7_h + (SumW'(1) <<< (RShift - 1))) >>> RShift;
    else            rnd = s7_h;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s7_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outside_map <= s7_out;
      if (s7_out) height <= '0;
      else if (rnd > SumW'(131071)) height <= HeightW'(131071);
      else if (rnd < -SumW'(131072)) height <= HeightW'(-131072);
      else height <= HeightW'(rnd);
    end
  end

  // ---------------------------------------------------------------------------
  property p_hold;
    @(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid;
  endproperty
  a_hold: assert property (p_hold) else $error("result item dropped under stall");

  property p_out_zero;
    @(posedge clk) disable iff (rst) (out_valid && outside_map) |-> (height == '0);
  endproperty
  a_out_zero: assert property (p_out_zero) else $error("outside item with non-zero height");

  property p_load_quiet;
    @(posedge clk) disable iff (rst) (adv && s4_v && !s4_q) |=> !s5_v;
  endproperty
  a_load_quiet: assert property (p_load_quiet) else $error("load item produced a result");

endmodule

[tb/sv/heightmap_bilinear_sampler_tb.sv]
// self-checking testbench for the heightmap bilinear sampler
module heightmap_bilinear_sampler_tb;
  import hmbs_pkg::*;

  typedef struct packed {
    logic                      act;
    logic [17:0]               idx;
    logic [7:0]                hgt;
    logic signed [WorldW-1:0]  wx;
    logic signed [WorldW-1:0]  wz;
    logic                      rq;
    logic                      typed;
    logic signed [HeightW-1:0] eh;
    logic                      eo;
  } row_t;

  typedef struct packed {
    logic signed [HeightW-1:0] h;
    logic                      o;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic action = 1'b0;
  logic [17:0] load_index = '0;
  logic [7:0] load_height = '0;
  logic signed [WorldW-1:0] world_x = '0, world_z = '0;
  logic reverse_quad = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic signed [HeightW-1:0] height;
  logic outside_map;

  // own copy of the map and the registers
  logic [7:0] heights [0:262143];
  bit         written [0:262143];
  int unsigned scale_x, scale_z, width_reg, length_reg;

  sample_t pending[$];
  int errors = 0;
  int sent = 0;
  bit calm = 1'b0;

  heightmap_bilinear_sampler i_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result height=%0d outside=%0b", $time, height, outside_map);
        errors++;
      end else begin
        if (height !== pending[0].h || outside_map !== pending[0].o) begin
          $display("%0t: mismatch expected height=%0d outside=%0b actual height=%0d outside=%0b",
                   $time, pending[0].h, pending[0].o, height, outside_map);
          errors++;
        end
        void'(pending.pop_front());
      end
    end
  end

  // bilinear height at a world position; also returns the four corner addresses
  function automatic sample_t interpolate(input logic signed [WorldW-1:0] wx,
                                          input logic signed [WorldW-1:0] wz,
                                          input logic rq, output logic [71:0] corners,
                                          output bit in_map);
    sample_t res;
    longint px, pz, gx, gz, w, l, x, z, x1, z1, fx, fz;
    longint bl, br, tl, tr, top, bot, h, r;
    w = (width_reg > 512) ? 512 : width_reg;
    l = (length_reg > 512) ? 512 : length_reg;
    px = longint'(wx) * longint'(scale_x);
    pz = longint'(wz) * longint'(scale_z);
    corners = '0;
    in_map = 1'b0;
    res.h = '0;
    res.o = 1'b1;
    if (px < 0 || pz < 0) return res;
    gx = px >>> 12;
    gz = pz >>> 12;
    x = gx >>> 8;
    z = gz >>> 8;
    if (x >= w || z >= l) return res;
    in_map = 1'b1;
    fx = gx & 255;
    fz = gz & 255;
    x1 = (x + 1 < w) ? x + 1 : x;
    z1 = (z + 1 < l) ? z + 1 : z;
    corners = {18'(x + z * w), 18'(x1 + z * w), 18'(x + z1 * w), 18'(x1 + z1 * w)};
    bl = heights[x + z * w];
    br = heights[x1 + z * w];
    tl = heights[x + z1 * w];
    tr = heights[x1 + z1 * w];
    if (rq) begin
      if (fz >= fx) br = bl + (tr - tl);
      else tl = tr + (bl - br);
    end else begin
      if (fz < 256 - fx) tr = tl + (br - bl);
      else bl = tl + (br - tr);
    end
    top = tl * (256 - fx) + tr * fx;
    bot = bl * (256 - fx) + br * fx;
    h = bot * (256 - fz) + top * fz;
    r = ((h + (longint'(1024) << 16) + 128) >>> 8) - (longint'(1024) << 8);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    res.h = HeightW'(r);
    res.o = 1'b0;
    return res;
  endfunction

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // drives one item and returns at the edge that accepts it
  task automatic send(input row_t it);
    logic [71:0] corners;
    bit in_map;
    sample_t s;
    idle_gap();
    in_valid <= 1'b1;
    action <= it.act;
    load_index <= it.idx;
    load_height <= it.hgt;
    world_x <= it.wx;
    world_z <= it.wz;
    reverse_quad <= it.rq;
    do @(posedge clk); while (in_stall);
    sent++;
    if (it.act == ACT_LOAD) begin
      heights[it.idx] = it.hgt;
      written[it.idx] = 1'b1;
    end else if (it.typed) begin
      s.h = it.eh;
      s.o = it.eo;
      pending.push_back(s);
    end else begin
      pending.push_back(interpolate(it.wx, it.wz, it.rq, corners, in_map));
    end
  endtask

  task automatic load(input logic [17:0] idx, input logic [7:0] hgt);
    row_t it;
    it = '0;
    it.act = ACT_LOAD;
    it.idx = idx;
    it.hgt = hgt;
    it.wx = WorldW'($urandom);
    it.wz = WorldW'($urandom);
    it.rq = 1'($urandom);
    send(it);
  endtask

  // query that first loads any corner it would read that holds no height yet
  task automatic query(input logic signed [WorldW-1:0] wx, input logic signed [WorldW-1:0] wz,
                       input logic rq);
    logic [71:0] corners;
    bit in_map;
    sample_t s;
    row_t it;
    s = interpolate(wx, wz, rq, corners, in_map);
    if (in_map) begin
      for (int k = 0; k < 4; k++) begin
        if (!written[corners[18*k +: 18]]) load(corners[18*k +: 18], 8'($urandom));
      end
    end
    it = '0;
    it.act = ACT_QUERY;
    it.idx = 18'($urandom);
    it.hgt = 8'($urandom);
    it.wx = wx;
    it.wz = wz;
    it.rq = rq;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_INV_SCALE_X: scale_x = v[15:0];
      REG_INV_SCALE_Z: scale_z = v[15:0];
      REG_MAP_WIDTH:   width_reg = v[9:0];
      default:         length_reg = v[9:0];
    endcase
  endtask

  // world coordinate aimed at a grid position, so most queries land inside the map
  function automatic logic signed [WorldW-1:0] aim(input int unsigned inv, input int unsigned dim);
    longint g, wv;
    if (dim > 512) dim = 512;
    if (inv == 0 || $urandom_range(0, 99) < 15) return WorldW'($urandom);
    g = $urandom_range(0, 99) < 10 ? longint'(dim) * 256 - $urandom_range(1, 300)
                                   : $urandom_range(0, dim * 256 + 200);
    if (g < 0) g = 0;
    wv = (g * 4096) / inv;
    if (wv > 8388607) wv = 8388607;
    return WorldW'(wv);
  endfunction

  row_t directed [22] = '{
    '{ACT_LOAD,  18'd0,      8'd255, 24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd1,      8'd0,   24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd512,    8'd255, 24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd513,    8'd0,   24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd0, 24'sd0, 1'b0, 1'b1, 18'sd65280, 1'b0},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd0, 24'sd0, 1'b1, 1'b1, 18'sd65280, 1'b0},
    // negative positions lie outside
    '{ACT_QUERY, 18'd0,      8'd0,   -24'sd1, 24'sd0, 1'b0, 1'b1, 18'sd0, 1'b1},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd0, -24'sd8388608, 1'b1, 1'b1, 18'sd0, 1'b1},
    // cell index past the map
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd8388607, 24'sd0, 1'b0, 1'b1, 18'sd0, 1'b1},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd0, 24'sd131072, 1'b0, 1'b1, 18'sd0, 1'b1},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd128, 24'sd128, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd128, 24'sd64, 1'b1, 1'b0, 18'sd0, 1'b0},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd64, 24'sd128, 1'b1, 1'b0, 18'sd0, 1'b0},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd200, 24'sd10, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd511,    8'd170, 24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd1023,   8'd85,  24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd262143, 8'd127, 24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd262142, 8'd128, 24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    // right and top neighbours clamp at the map edge
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd131016, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd131071, 24'sd131071, 1'b1, 1'b0, 18'sd0, 1'b0},
    '{ACT_QUERY, 18'd0,      8'd0,   24'sd130660, 24'sd130866, 1'b0, 1'b0, 18'sd0, 1'b0},
    '{ACT_LOAD,  18'd262143, 8'd255, 24'sd0, 24'sd0, 1'b0, 1'b0, 18'sd0, 1'b0}
  };

  // inv_scale_x, inv_scale_z, width, length; zero and oversized dimensions included
  int unsigned settings [8][4] = '{
    '{4096, 4096, 512, 512}, '{65535, 65535, 2, 2}, '{1, 1, 512, 512},
    '{0, 4096, 1023, 700}, '{3000, 5000, 37, 19}, '{4096, 4096, 0, 5},
    '{65535, 1, 3, 512}, '{8192, 2048, 16, 16}
  };

  initial begin
    int goal;
    int n;
    for (int k = 0; k < 262144; k++) written[k] = 1'b0;
    scale_x = 4096;
    scale_z = 4096;
    width_reg = 512;
    length_reg = 512;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[k]) send(directed[k]);
    drain();
    for (int ph = 0; ph < 11; ph++) begin
      if (ph < 8) begin
        write_reg(REG_INV_SCALE_X, settings[ph][0]);
        write_reg(REG_INV_SCALE_Z, settings[ph][1]);
        write_reg(REG_MAP_WIDTH, settings[ph][2]);
        write_reg(REG_MAP_LENGTH, settings[ph][3]);
      end else begin
        write_reg(REG_INV_SCALE_X, $urandom_range(1, 65535));
        write_reg(REG_INV_SCALE_Z, $urandom_range(1, 65535));
        write_reg(REG_MAP_WIDTH, $urandom_range(2, 64));
        write_reg(REG_MAP_LENGTH, $urandom_range(2, 64));
      end
      calm = (ph == 2);
      // item budget per phase counts the corner loads as well
      goal = sent + 108;
      n = 0;
      while (sent < goal) begin
        if (n == 55) begin
          // hold off until the pipeline has emptied
          in_valid <= 1'b0;
          do @(posedge clk); while (pending.size() != 0);
        end
        if ($urandom_range(0, 99) < 15) load(18'($urandom), 8'($urandom));
        else query(aim(scale_x, width_reg), aim(scale_z, length_reg), 1'($urandom));
        n++;
      end
      calm = 1'b0;
      drain();
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/core/hmbs_pkg.sv
rtl/core/hmbs_bank.sv
rtl/core/heightmap_bilinear_sampler.sv
tb/sv/heightmap_bilinear_sampler_tb.sv
